FILE: rtl/smmv_pkg.sv
// ----------------------------------------------------------------------------
// smmv_pkg
// Shared widths, sizes and controller/datapath interface types for the
// streaming min / max / mean / variance core.
// ----------------------------------------------------------------------------
package smmv_pkg;

  // sample and set sizes
  localparam int SampleBits = 16;
  localparam int MaxSetSize = 1024;
  localparam int CountBits  = 11;

  // accumulator widths: sum of up to 1024 samples, sum of their squares
  localparam int SquareBits = 2 * SampleBits;
  localparam int SumBits    = 27;
  localparam int SqBits     = 41;

  // n*sumsq and sum^2 both stay below 2^51
  localparam int ProdBits   = 51;
  localparam int FracBits   = 16;

  // shared divider: dividend is (n*sumsq - sum^2) * 2^16, divisor up to n^2
  localparam int DvdBits    = ProdBits + FracBits;
  localparam int DvsBits    = 2 * CountBits - 1;
  localparam int RemBits    = DvsBits;
  localparam int DivCntBits = 7;

  // result widths
  localparam int MeanBits   = 32;
  localparam int VarBits    = 46;

  // controller to datapath commands
  typedef struct packed {
    logic acc;             // fold the accepted sample into the accumulators
    logic mul;             // register n*sumsq, sum^2 and n^2
    logic div_start_mean;  // start the divider on |sum| * 2^16 / n
    logic div_start_var;   // start the divider on the variance numerator
    logic save_mean;       // capture the rounded mean from the divider
    logic load_out;        // load the output registers and clear the set
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic at_limit;        // the next sample fills the set
    logic div_done;        // divider result is valid this cycle
  } dp_sts_t;

endpackage

FILE: rtl/stream_min_max_mean_variance_core.sv
// ----------------------------------------------------------------------------
// stream_min_max_mean_variance_core
// Running max, min, mean and population variance over sets of samples.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o): one signed sample per beat, with
// last_sample_i marking the end of a set. A set also closes on its 1024th
// sample. Samples are folded in at one beat per cycle while in_ready_o is high.
// Output channel (out_valid_o / out_ready_i): one beat per set carrying
// max, min, mean * 2^16 and variance * 2^16 (both floor rounded) and the
// sample count.
// After the closing beat, in_ready_o stays low while the product stage is
// registered and two 67-step restoring divisions (mean, then variance) run
// on the shared divider; the result is then loaded into the output
// registers. The divider sets the per-set cost.
// Receiver stall: the output registers hold a result while the next set is
// accumulated; a new result waits in the controller until the previous beat
// has been taken.
// Reset: clears sum, sumsq and count, the controller and the output valid flag.
// ----------------------------------------------------------------------------
module stream_min_max_mean_variance_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [smmv_pkg::SampleBits-1:0] sample_i,
  input  logic                                   last_sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [smmv_pkg::SampleBits-1:0] max_value_o,
  output logic signed [smmv_pkg::SampleBits-1:0] min_value_o,
  output logic signed [smmv_pkg::MeanBits-1:0]   mean_fixed_o,
  output logic [smmv_pkg::VarBits-1:0]           variance_fixed_o,
  output logic [smmv_pkg::CountBits-1:0]         sample_count_o
);

  smmv_pkg::dp_cmd_t cmd;
  smmv_pkg::dp_sts_t sts;

  // controller
  smmv_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .last_sample_i (last_sample_i),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  // datapath
  smmv_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .sample_i         (sample_i),
    .max_value_o      (max_value_o),
    .min_value_o      (min_value_o),
    .mean_fixed_o     (mean_fixed_o),
    .variance_fixed_o (variance_fixed_o),
    .sample_count_o   (sample_count_o)
  );

  // a closing beat stops the input until the result is computed
  a_close_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_sample_i |=> !in_ready_o)
    else $error("input still ready after a closing beat");

  // a result always covers at least one sample
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_count_o != '0)
    else $error("result with zero samples");

  // max never below min in a result
  a_max_ge_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> max_value_o >= min_value_o)
    else $error("max below min in result");

  // divider only finishes while samples are held off
  a_div_idle_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.div_done |-> !in_ready_o)
    else $error("divider finished while accepting samples");

endmodule

FILE: rtl/smmv_div.sv
// ----------------------------------------------------------------------------
// smmv_div
// Restoring unsigned divider, one quotient bit per cycle. The quotient is
// shifted into the dividend register; the remainder is kept alongside.
// ----------------------------------------------------------------------------
module smmv_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [smmv_pkg::DvdBits-1:0]   dividend_i,
  input  logic [smmv_pkg::DvsBits-1:0]   divisor_i,
  output logic [smmv_pkg::DvdBits-1:0]   quot_o,
  output logic [smmv_pkg::RemBits-1:0]   rem_o,
  output logic                           done_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [smmv_pkg::DivCntBits-1:0]   cnt_q, cnt_d;
  logic [smmv_pkg::DvdBits-1:0]      dvd_q, dvd_d;
  logic [smmv_pkg::DvsBits-1:0]      dvs_q, dvs_d;
  logic [smmv_pkg::RemBits-1:0]      rem_q, rem_d;

  logic [smmv_pkg::RemBits:0]        rem_sh;
  logic [smmv_pkg::RemBits:0]        rem_sub;
  logic                              ge;

  // one restoring step
  assign rem_sh  = {rem_q, dvd_q[smmv_pkg::DvdBits-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  // step sequencing
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    done_d = busy_q && (cnt_q == '0);
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = smmv_pkg::DivCntBits'(smmv_pkg::DvdBits - 1);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      done_d = 1'b0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[smmv_pkg::DvdBits-2:0], ge};
      rem_d = ge ? rem_sub[smmv_pkg::RemBits-1:0] : rem_sh[smmv_pkg::RemBits-1:0];
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign quot_o = dvd_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

FILE: rtl/smmv_dp.sv
// ----------------------------------------------------------------------------
// smmv_dp
// Datapath: running accumulators, product stage, shared divider and the
// output registers.
// ----------------------------------------------------------------------------
module smmv_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  smmv_pkg::dp_cmd_t                     cmd_i,
  output smmv_pkg::dp_sts_t                     sts_o,
  input  logic signed [smmv_pkg::SampleBits-1:0] sample_i,
  output logic signed [smmv_pkg::SampleBits-1:0] max_value_o,
  output logic signed [smmv_pkg::SampleBits-1:0] min_value_o,
  output logic signed [smmv_pkg::MeanBits-1:0]   mean_fixed_o,
  output logic [smmv_pkg::VarBits-1:0]           variance_fixed_o,
  output logic [smmv_pkg::CountBits-1:0]         sample_count_o
);

  // accumulators
  logic signed [smmv_pkg::SampleBits-1:0] max_q, max_d;
  logic signed [smmv_pkg::SampleBits-1:0] min_q, min_d;
  logic signed [smmv_pkg::SumBits-1:0]    sum_q, sum_d;
  logic [smmv_pkg::SqBits-1:0]            sumsq_q, sumsq_d;
  logic [smmv_pkg::CountBits-1:0]         count_q, count_d;

  // product stage
  logic [smmv_pkg::ProdBits-1:0]          nss_q;
  logic [smmv_pkg::ProdBits-1:0]          ss_q;
  logic [smmv_pkg::DvsBits-1:0]           nsq_q;

  logic signed [smmv_pkg::SquareBits-1:0]          samp_sq;
  logic [smmv_pkg::CountBits+smmv_pkg::SqBits-1:0] nss_full;
  logic signed [2*smmv_pkg::SumBits-1:0]           ss_full;
  logic [2*smmv_pkg::CountBits-1:0]                nsq_full;
  logic                                            first;

  // divider operands and results
  logic [smmv_pkg::SumBits-1:0]   sum_mag;
  logic [smmv_pkg::ProdBits-1:0]  var_num;
  logic [smmv_pkg::DvdBits-1:0]   div_dvd;
  logic [smmv_pkg::DvsBits-1:0]   div_dvs;
  logic [smmv_pkg::DvdBits-1:0]   div_quot;
  logic [smmv_pkg::RemBits-1:0]   div_rem;
  logic                           div_done;

  // mean rounding and output registers
  logic [smmv_pkg::MeanBits-1:0]  mean_up;
  logic [smmv_pkg::MeanBits-1:0]  mean_d;
  logic [smmv_pkg::MeanBits-1:0]  mean_q;

  logic signed [smmv_pkg::SampleBits-1:0] max_out_q;
  logic signed [smmv_pkg::SampleBits-1:0] min_out_q;
  logic [smmv_pkg::MeanBits-1:0]          mean_out_q;
  logic [smmv_pkg::VarBits-1:0]           var_out_q;
  logic [smmv_pkg::CountBits-1:0]         count_out_q;

  // sample update
  assign first   = (count_q == '0);
  assign samp_sq = sample_i * sample_i;

  always_comb begin
    max_d   = max_q;
    min_d   = min_q;
    sum_d   = sum_q;
    sumsq_d = sumsq_q;
    count_d = count_q;
    if (cmd_i.load_out) begin
      sum_d   = '0;
      sumsq_d = '0;
      count_d = '0;
    end else if (cmd_i.acc) begin
      if (first || (sample_i > max_q)) max_d = sample_i;
      if (first || (sample_i < min_q)) min_d = sample_i;
      sum_d   = sum_q + {{(smmv_pkg::SumBits-smmv_pkg::SampleBits){sample_i[smmv_pkg::SampleBits-1]}},
                         sample_i};
      sumsq_d = sumsq_q + {{(smmv_pkg::SqBits-smmv_pkg::SquareBits){1'b0}}, samp_sq};
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sumsq_q <= '0;
      count_q <= '0;
    end else begin
      sum_q   <= sum_d;
      sumsq_q <= sumsq_d;
      count_q <= count_d;
    end
  end

  // max and min are loaded by the first sample of every set
  always_ff @(posedge clk_i) begin
    max_q <= max_d;
    min_q <= min_d;
  end

  // products for the variance numerator and divisor
  assign nss_full = count_q * sumsq_q;
  assign ss_full  = sum_q * sum_q;
  assign nsq_full = count_q * count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      nss_q <= nss_full[smmv_pkg::ProdBits-1:0];
      ss_q  <= ss_full[smmv_pkg::ProdBits-1:0];
      nsq_q <= nsq_full[smmv_pkg::DvsBits-1:0];
    end
  end

  // divider operand select
  assign sum_mag = sum_q[smmv_pkg::SumBits-1] ? (~sum_q + 1'b1) : sum_q;
  assign var_num = nss_q - ss_q;

  always_comb begin
    if (cmd_i.div_start_mean) begin
      div_dvd = {{(smmv_pkg::DvdBits-smmv_pkg::SumBits-smmv_pkg::FracBits){1'b0}},
                 sum_mag, {smmv_pkg::FracBits{1'b0}}};
      div_dvs = {{(smmv_pkg::DvsBits-smmv_pkg::CountBits){1'b0}}, count_q};
    end else begin
      div_dvd = {var_num, {smmv_pkg::FracBits{1'b0}}};
      div_dvs = nsq_q;
    end
  end

  smmv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start_mean | cmd_i.div_start_var),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  // floor for negative sums: -(q + (r != 0))
  assign mean_up = div_quot[smmv_pkg::MeanBits-1:0]
                 + {{(smmv_pkg::MeanBits-1){1'b0}}, |div_rem};
  assign mean_d  = sum_q[smmv_pkg::SumBits-1] ? (~mean_up + 1'b1)
                                              : div_quot[smmv_pkg::MeanBits-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.save_mean) begin
      mean_q <= mean_d;
    end
  end

  // output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      max_out_q   <= max_q;
      min_out_q   <= min_q;
      mean_out_q  <= mean_q;
      var_out_q   <= div_quot[smmv_pkg::VarBits-1:0];
      count_out_q <= count_q;
    end
  end

  assign max_value_o      = max_out_q;
  assign min_value_o      = min_out_q;
  assign mean_fixed_o     = mean_out_q;
  assign variance_fixed_o = var_out_q;
  assign sample_count_o   = count_out_q;

  // status
  assign sts_o.at_limit = (count_q == smmv_pkg::CountBits'(smmv_pkg::MaxSetSize - 1));
  assign sts_o.div_done = div_done;

endmodule

FILE: rtl/smmv_ctrl.sv
// ----------------------------------------------------------------------------
// smmv_ctrl
// Controller: accepts samples, sequences the product stage and the two
// divisions after a set closes, and owns the output valid flag.
// ----------------------------------------------------------------------------
module smmv_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               last_sample_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output smmv_pkg::dp_cmd_t  cmd_o,
  input  smmv_pkg::dp_sts_t  sts_i
);

  localparam logic [2:0] StAcc  = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StMean = 3'd2;
  localparam logic [2:0] StVar  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StAcc: begin
        in_ready_o = 1'b1;
        cmd_o.acc  = in_valid_i;
        if (in_valid_i && (last_sample_i || sts_i.at_limit)) state_d = StMul;
      end
      StMul: begin
        cmd_o.mul            = 1'b1;
        cmd_o.div_start_mean = 1'b1;
        state_d              = StMean;
      end
      StMean: begin
        if (sts_i.div_done) begin
          cmd_o.save_mean     = 1'b1;
          cmd_o.div_start_var = 1'b1;
          state_d             = StVar;
        end
      end
      StVar: begin
        if (sts_i.div_done) state_d = StOut;
      end
      StOut: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StAcc;
        end
      end
      default: begin
        state_d = StAcc;
      end
    endcase
  end

  // output valid: set on load, cleared when the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StAcc;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for stream_min_max_mean_variance_core. Sets of signed samples are
// sent over the input stream. A set statistics predictor inside the bench
// builds the expected max, min, floor mean, floor population variance and
// count for every closed set. Each output beat is compared field by field.
// Directed extremes, a set closed by the size limit and random sets are sent,
// with random gaps on both sides outside a no-gap stretch, and drain pauses.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CycleLimit = 1_500_000;
  localparam int DrainCycles = 200;

  typedef struct packed {
    logic signed [smmv_pkg::SampleBits-1:0] hi;
    logic signed [smmv_pkg::SampleBits-1:0] lo;
    logic signed [smmv_pkg::MeanBits-1:0]   mean;
    logic [smmv_pkg::VarBits-1:0]           variance;
    logic [smmv_pkg::CountBits-1:0]         count;
  } set_stats_t;

  logic                                   clk_i = 1'b0;
  logic                                   rst_ni = 1'b0;
  logic                                   in_valid_i = 1'b0;
  logic                                   in_ready_o;
  logic signed [smmv_pkg::SampleBits-1:0] sample_i = '0;
  logic                                   last_sample_i = 1'b0;
  logic                                   out_valid_o;
  logic                                   out_ready_i = 1'b0;
  logic signed [smmv_pkg::SampleBits-1:0] max_value_o;
  logic signed [smmv_pkg::SampleBits-1:0] min_value_o;
  logic signed [smmv_pkg::MeanBits-1:0]   mean_fixed_o;
  logic [smmv_pkg::VarBits-1:0]           variance_fixed_o;
  logic [smmv_pkg::CountBits-1:0]         sample_count_o;

  // running statistics of the open set
  logic signed [smmv_pkg::SampleBits-1:0] acc_max;
  logic signed [smmv_pkg::SampleBits-1:0] acc_min;
  longint                                 acc_sum = 0;
  longint unsigned                        acc_sumsq = 0;
  longint unsigned                        acc_n = 0;

  set_stats_t expected_stats[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          no_gaps = 1'b0;

  stream_min_max_mean_variance_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_i         (sample_i),
    .last_sample_i    (last_sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .max_value_o      (max_value_o),
    .min_value_o      (min_value_o),
    .mean_fixed_o     (mean_fixed_o),
    .variance_fixed_o (variance_fixed_o),
    .sample_count_o   (sample_count_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= no_gaps || ($urandom_range(99) >= 14);
  end

  // fold one accepted sample, close the set on the flag or the size limit
  function automatic void fold_sample(logic signed [smmv_pkg::SampleBits-1:0] s, logic last);
    longint          wide;
    longint unsigned mag, quo, rem, diff, n_sq, usum;
    logic [63:0]     mean_wide, var_wide;
    set_stats_t      want;
    wide = s;
    if (acc_n == 0) begin
      acc_max = s;
      acc_min = s;
    end else begin
      if (s > acc_max) acc_max = s;
      if (s < acc_min) acc_min = s;
    end
    acc_sum   = acc_sum + wide;
    acc_sumsq = acc_sumsq + longint'(wide * wide);
    acc_n     = acc_n + 1;
    if (!last && acc_n < smmv_pkg::MaxSetSize) return;

    // mean: floor(sum * 2^16 / n)
    mag = (acc_sum < 0) ? longint'(-acc_sum) : acc_sum;
    quo = (mag << smmv_pkg::FracBits) / acc_n;
    rem = (mag << smmv_pkg::FracBits) % acc_n;
    mean_wide = (acc_sum < 0) ? (64'd0 - (quo + (rem != 0))) : quo;

    // variance: floor((n*sumsq - sum^2) * 2^16 / n^2), split to stay in 64 bits
    usum = acc_sum;
    diff = acc_n * acc_sumsq - usum * usum;
    n_sq = acc_n * acc_n;
    var_wide = ((diff / n_sq) << smmv_pkg::FracBits)
             + (((diff % n_sq) << smmv_pkg::FracBits) / n_sq);

    want.hi       = acc_max;
    want.lo       = acc_min;
    want.mean     = mean_wide[smmv_pkg::MeanBits-1:0];
    want.variance = var_wide[smmv_pkg::VarBits-1:0];
    want.count    = acc_n[smmv_pkg::CountBits-1:0];
    expected_stats.push_back(want);

    acc_sum   = 0;
    acc_sumsq = 0;
    acc_n     = 0;
  endfunction

  function automatic void compare_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch in %s: expected %0h, got %0h", field, want, got);
    end
  endfunction

  // output beat checker, sampled mid-cycle before the accepting edge
  always @(negedge clk_i) begin
    set_stats_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_stats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result beat with no open expectation: count %0d", sample_count_o);
      end else begin
        want = expected_stats.pop_front();
        compare_field("max_value", max_value_o, want.hi);
        compare_field("min_value", min_value_o, want.lo);
        compare_field("mean_fixed", mean_fixed_o, want.mean);
        compare_field("variance_fixed", variance_fixed_o, want.variance);
        compare_field("sample_count", sample_count_o, want.count);
      end
    end
  end

  // send one sample beat; valid stays up after the beat for the next call
  task automatic send_sample(logic signed [smmv_pkg::SampleBits-1:0] s, logic last);
    while (!no_gaps && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_i      <= s;
    last_sample_i <= last;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    fold_sample(s, last);
  endtask

  // hold the input side until every set result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_stats.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [smmv_pkg::SampleBits-1:0] random_sample();
    logic [smmv_pkg::SampleBits-1:0] raw;
    case ($urandom_range(7))
      0:       raw = 16'h7fff;
      1:       raw = 16'h8000;
      2:       raw = 16'($urandom_range(8)) - 16'd4;
      default: raw = 16'($urandom);
    endcase
    return raw;
  endfunction

  // one-sample sets at the extremes and around zero
  task automatic test_single_sample_sets();
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b1);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd1, 1'b1);
  endtask

  // short sets: widest spread, constant minimum, floor of negative mean
  task automatic test_small_sets();
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd2, 1'b1);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd2, 1'b1);
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd3, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(-16'sd7, 1'b1);
  endtask

  // full set with no flag: the size limit closes it, at maximum variance
  task automatic test_full_length_set();
    int k;
    for (k = 0; k < smmv_pkg::MaxSetSize; k++)
      send_sample(k[0] ? 16'sh8000 : 16'sh7fff, 1'b0);
    send_sample(16'sd3, 1'b1);
    drain_results();
  endtask

  // random sets, mostly short, some longer
  task automatic test_random_sets(int unsigned items);
    int unsigned sent, len, k;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(80, 13) : $urandom_range(12, 1);
      for (k = 1; k <= len; k++)
        send_sample(random_sample(), k == len);
      sent += len;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_sample_sets();
    test_small_sets();
    test_full_length_set();

    // back to back stretch with no gaps on either side
    no_gaps = 1'b1;
    test_random_sets(300);
    no_gaps = 1'b0;

    test_random_sets(300);
    drain_results();
    test_random_sets(300);

    in_valid_i <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
